// File: rtl/poly_va_pkg.sv
// ----------------------------------------------------------------------------
// poly_va_pkg
// Shared types, codes and constants for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package poly_va_pkg;

    localparam int DEF_VOICES = 8;

    localparam logic [6:0] CTL_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CTL_ALL_NOTES_OFF = 7'd123;
    localparam logic [6:0] NOTE_RESET        = 7'd60;
    localparam logic [6:0] VEL_ZERO          = 7'd0;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_CTRL     = 2'd2,
        CMD_FINISHED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_IGNORE   = 3'd0,
        ACT_ASSIGN   = 3'd1,
        ACT_NOTE_REL = 3'd2,
        ACT_ALL_REL  = 3'd3,
        ACT_FREED    = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_ASSIGN,
        OP_RELEASE,
        OP_ALL,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESP
    } t_state;

    // one voice table entry
    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic        gate;
        logic        active;
        logic [31:0] age;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        note:     NOTE_RESET,
        velocity: VEL_ZERO,
        gate:     1'b0,
        active:   1'b0,
        age:      32'd0
    };

    // one result beat
    typedef struct packed {
        t_action     action;
        logic [2:0]  voice_slot;
        logic        stolen;
        logic [7:0]  release_mask;
        logic [3:0]  live_voices;
        logic [31:0] steal_total;
    } t_result;

endpackage

// File: rtl/poly_va_mem.sv
// ----------------------------------------------------------------------------
// poly_va_mem
// Voice table RAM: one write port, one registered read port, per-entry
// valid bits so unwritten voices read as their reset value.
// ----------------------------------------------------------------------------
module poly_va_mem #(
    parameter int VOICES = poly_va_pkg::DEF_VOICES,
    parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [VW-1:0]        i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [VW-1:0]        i_wr_addr,
    input  poly_va_pkg::t_entry  i_wr_data,
    output poly_va_pkg::t_entry  o_rd_data
);
    import poly_va_pkg::*;

    t_entry              mem [VOICES];
    logic [VOICES-1:0]   r_valid;
    t_entry              r_rd;
    logic                r_rd_vld;
    logic                fwd;

    assign fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= fwd ? i_wr_data : mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr] || fwd;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : ENTRY_RESET;

endmodule

// File: rtl/poly_va_seq.sv
// ----------------------------------------------------------------------------
// poly_va_seq
// Event sequencer: decodes one event, scans the voice table through the
// RAM read port, writes back modified entries and builds the result.
// ----------------------------------------------------------------------------
module poly_va_seq #(
    parameter int VOICES = poly_va_pkg::DEF_VOICES,
    parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_command,
    input  logic [3:0]           i_channel,
    input  logic [6:0]           i_note,
    input  logic [6:0]           i_velocity,
    input  logic [6:0]           i_controller,
    input  logic [2:0]           i_voice_index,
    input  logic [3:0]           i_listen_ch,
    input  logic                 i_res_free,
    output logic                 o_busy,
    output logic                 o_done,
    output poly_va_pkg::t_result o_res,
    output logic                 o_rd_en,
    output logic [VW-1:0]        o_rd_addr,
    output logic                 o_wr_en,
    output logic [VW-1:0]        o_wr_addr,
    output poly_va_pkg::t_entry  o_wr_data,
    input  poly_va_pkg::t_entry  i_rd_data
);
    import poly_va_pkg::*;

    localparam int CW = $clog2(VOICES + 1);
    localparam logic [CW-1:0] CNT_VOICES = CW'(VOICES);

    t_state        r_state, n_state;
    t_op           r_op, start_op;
    logic [6:0]    r_key, r_vel;
    logic [CW-1:0] r_rd_cnt, r_end;
    logic          r_dv;
    logic [VW-1:0] r_d_idx;
    logic          r_found_free, r_found_off;
    logic [VW-1:0] r_free_idx, r_off_idx, r_best_idx, r_slot;
    logic [31:0]   r_best_age;
    logic [7:0]    r_mask;
    t_action       r_action;
    logic          r_stolen;
    logic [CW-1:0] r_act_cnt;
    logic [31:0]   r_stamp, r_steals;

    logic          issue, on_ch, fin_ok, steal;
    logic [VW-1:0] chosen;
    logic [CW+2:0] vidx_wide;
    logic [CW-1:0] vidx_cnt;
    logic [VW+2:0] slot_wide;
    logic [CW+3:0] cnt_wide;
    logic [7:0]    idx_bit;
    t_entry        e;

    assign e         = i_rd_data;
    assign on_ch     = (i_channel == i_listen_ch);
    assign fin_ok    = (int'(i_voice_index) < VOICES);
    assign vidx_wide = {{CW{1'b0}}, i_voice_index};
    assign vidx_cnt  = vidx_wide[CW-1:0];
    assign issue     = (r_state == S_SCAN) && (r_rd_cnt < r_end);
    assign steal     = !r_found_free && !r_found_off;
    assign chosen    = r_found_free ? r_free_idx : (r_found_off ? r_off_idx : r_best_idx);

    always_comb begin
        start_op = OP_IGNORE;
        case (t_cmd'(i_command))
            CMD_NOTE_ON: begin
                if (on_ch) start_op = (i_velocity != VEL_ZERO) ? OP_ASSIGN : OP_RELEASE;
            end
            CMD_NOTE_OFF: begin
                if (on_ch) start_op = OP_RELEASE;
            end
            CMD_CTRL: begin
                if (on_ch && (i_controller == CTL_ALL_SOUND_OFF ||
                              i_controller == CTL_ALL_NOTES_OFF)) start_op = OP_ALL;
            end
            CMD_FINISHED: begin
                if (fin_ok) start_op = OP_FINISH;
            end
            default: start_op = OP_IGNORE;
        endcase
    end

    // release-mask bit for the entry coming back from RAM (voices 0..7 only)
    always_comb begin
        idx_bit = '0;
        for (int b = 0; b < 8; b++) begin
            if (int'(r_d_idx) == b) idx_bit[b] = 1'b1;
        end
    end

    // next state and RAM control
    always_comb begin
        n_state   = r_state;
        o_done    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_d_idx;
        o_wr_data = e;
        o_rd_en   = issue;
        o_rd_addr = r_rd_cnt[VW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = (start_op == OP_IGNORE) ? S_RESP : S_SCAN;
            end
            S_SCAN: begin
                if (r_dv) begin
                    case (r_op)
                        OP_RELEASE: begin
                            if (e.active && e.note == r_key && e.gate) begin
                                o_wr_en        = 1'b1;
                                o_wr_data.gate = 1'b0;
                            end
                        end
                        OP_ALL: begin
                            if (e.gate) begin
                                o_wr_en        = 1'b1;
                                o_wr_data.gate = 1'b0;
                            end
                        end
                        OP_FINISH: begin
                            if (e.active && !e.gate) begin
                                o_wr_en          = 1'b1;
                                o_wr_data.active = 1'b0;
                            end
                        end
                        default: o_wr_en = 1'b0;
                    endcase
                end
                if (!issue && !r_dv) n_state = (r_op == OP_ASSIGN) ? S_WRITE : S_RESP;
            end
            S_WRITE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = chosen;
                o_wr_data = '{note: r_key, velocity: r_vel, gate: 1'b1,
                              active: 1'b1, age: r_stamp};
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_res_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dv      <= 1'b0;
            r_act_cnt <= '0;
            r_stamp   <= 32'd1;
            r_steals  <= '0;
        end else begin
            r_state <= n_state;
            r_dv    <= issue;
            if (r_state == S_SCAN && r_dv && r_op == OP_FINISH && e.active && !e.gate) begin
                r_act_cnt <= r_act_cnt - CW'(1);
            end
            if (r_state == S_WRITE) begin
                r_stamp <= r_stamp + 32'd1;
                if (r_found_free) r_act_cnt <= r_act_cnt + CW'(1);
                if (steal)        r_steals  <= r_steals + 32'd1;
            end
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op         <= start_op;
            r_key        <= i_note;
            r_vel        <= i_velocity;
            r_rd_cnt     <= (start_op == OP_FINISH) ? vidx_cnt : '0;
            r_end        <= (start_op == OP_FINISH) ? vidx_cnt + CW'(1) : CNT_VOICES;
            r_found_free <= 1'b0;
            r_found_off  <= 1'b0;
            r_mask       <= '0;
            r_slot       <= '0;
            r_stolen     <= 1'b0;
            case (start_op)
                OP_ASSIGN:  r_action <= ACT_ASSIGN;
                OP_RELEASE: r_action <= ACT_NOTE_REL;
                OP_ALL:     r_action <= ACT_ALL_REL;
                default:    r_action <= ACT_IGNORE;
            endcase
        end
        if (issue) begin
            r_rd_cnt <= r_rd_cnt + CW'(1);
            r_d_idx  <= r_rd_cnt[VW-1:0];
        end
        if (r_state == S_SCAN && r_dv) begin
            case (r_op)
                OP_ASSIGN: begin
                    if (!e.active && !r_found_free) begin
                        r_found_free <= 1'b1;
                        r_free_idx   <= r_d_idx;
                    end
                    if (!e.gate && !r_found_off) begin
                        r_found_off <= 1'b1;
                        r_off_idx   <= r_d_idx;
                    end
                    // ascending scan with strict compare keeps lowest index on ties
                    if (r_d_idx == '0 || e.age < r_best_age) begin
                        r_best_idx <= r_d_idx;
                        r_best_age <= e.age;
                    end
                end
                OP_RELEASE: begin
                    if (e.active && e.note == r_key && e.gate) r_mask <= r_mask | idx_bit;
                end
                OP_ALL: begin
                    if (e.gate) r_mask <= r_mask | idx_bit;
                end
                OP_FINISH: begin
                    if (e.active && !e.gate) begin
                        r_action <= ACT_FREED;
                        r_slot   <= r_d_idx;
                    end
                end
                default: r_mask <= r_mask;
            endcase
        end
        if (r_state == S_WRITE) begin
            r_slot   <= chosen;
            r_stolen <= steal;
        end
    end

    assign slot_wide = {3'b000, r_slot};
    assign cnt_wide  = {4'b0000, r_act_cnt};
    assign o_busy    = (r_state != S_IDLE);

    assign o_res = '{
        action:       r_action,
        voice_slot:   slot_wide[2:0],
        stolen:       r_stolen,
        release_mask: r_mask,
        live_voices:  cnt_wide[3:0],
        steal_total:  r_steals
    };

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_cnt <= CNT_VOICES)
        else $error("active count beyond table size");

    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_SCAN || r_state == S_WRITE))
        else $error("table write outside scan or write state");

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> i_res_free)
        else $error("result issued while output register is held");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_RESP))
        else $error("assign write not followed by result");

endmodule

// File: rtl/poly_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_unit
// Polyphonic voice allocator with oldest-voice stealing, table held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall, one event per beat (command, channel,
//   note, velocity, controller, voice_index). A beat is taken when i_valid
//   is high and o_stall is low. o_stall is high while an event is in work.
//   Output channel: o_valid / i_stall, exactly one result beat per event.
//   Config: i_cfg_we / i_cfg_data load listen_channel; write only when idle.
// Scan:
//   Note and controller events scan all VOICES entries through the single
//   registered RAM read port; a note-on then adds the write of the chosen
//   voice, and the unit passes through idle before the next accept. Voice
//   finished reads one entry, ignored events skip the scan.
// Reset:
//   Synchronous, active low. Voice valid bits clear at once, so every voice
//   reads as its reset value (note 60, all else zero); stamp restarts at 1.
// Stall:
//   A result waits in the output register; the next event is still taken
//   and worked, and its result holds in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module poly_voice_allocator_unit #(
    parameter int VOICES = poly_va_pkg::DEF_VOICES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_velocity,
    input  logic [6:0]  i_controller,
    input  logic [2:0]  i_voice_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [2:0]  o_voice_slot,
    output logic        o_stolen,
    output logic [7:0]  o_release_mask,
    output logic [3:0]  o_live_voices,
    output logic [31:0] o_steal_total,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    import poly_va_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [3:0]    r_listen;
    logic          r_out_valid;
    t_result       r_out;

    logic          start, busy, done, res_free;
    t_result       res;
    logic          rd_en, wr_en;
    logic [VW-1:0] rd_addr, wr_addr;
    t_entry        wr_data, rd_data;

    // event accepted only while the sequencer is idle
    assign o_stall  = busy;
    assign start    = i_valid && !busy;
    // output slot free when empty or being drained this cycle
    assign res_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_listen <= i_cfg_data;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_out <= res;
    end

    poly_va_seq #(
        .VOICES (VOICES),
        .VW     (VW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_note        (i_note),
        .i_velocity    (i_velocity),
        .i_controller  (i_controller),
        .i_voice_index (i_voice_index),
        .i_listen_ch   (r_listen),
        .i_res_free    (res_free),
        .o_busy        (busy),
        .o_done        (done),
        .o_res         (res),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_rd_data     (rd_data)
    );

    poly_va_mem #(
        .VOICES (VOICES),
        .VW     (VW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign o_valid        = r_out_valid;
    assign o_action       = r_out.action;
    assign o_voice_slot   = r_out.voice_slot;
    assign o_stolen       = r_out.stolen;
    assign o_release_mask = r_out.release_mask;
    assign o_live_voices  = r_out.live_voices;
    assign o_steal_total  = r_out.steal_total;

endmodule

// File: verif/poly_voice_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_unit_tb
// Self-checking bench for the voice allocator. A queue of MIDI-style events
// feeds a clocked driver. Every beat that the block takes is run through a
// behavioral allocator in the bench, which queues the result it expects.
// A clocked monitor pops that queue on each result beat and compares every
// field. Both sides idle and stall in random bursts, and the listen channel
// is moved between phases while the block is quiet.
// ----------------------------------------------------------------------------
module poly_voice_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import poly_va_pkg::*;

    localparam int NUM_VOICES  = DEF_VOICES;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_CAP   = 50;

    // one input beat, as the driver presents it
    typedef struct {
        t_cmd       cmd;
        logic [3:0] chan;
        logic [6:0] note;
        logic [6:0] vel;
        logic [6:0] ctl;
        logic [2:0] vidx;
    } t_midi_event;

    // DUT ports
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command      = '0;
    logic [3:0]  i_channel      = '0;
    logic [6:0]  i_note         = '0;
    logic [6:0]  i_velocity     = '0;
    logic [6:0]  i_controller   = '0;
    logic [2:0]  i_voice_index  = '0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [2:0]  o_action;
    logic [2:0]  o_voice_slot;
    logic        o_stolen;
    logic [7:0]  o_release_mask;
    logic [3:0]  o_live_voices;
    logic [31:0] o_steal_total;
    logic        i_cfg_we       = 1'b0;
    logic [3:0]  i_cfg_data     = '0;

    // bench copy of the voice table and counters
    logic [6:0]  voice_key_tb   [NUM_VOICES];
    logic [6:0]  voice_vel_tb   [NUM_VOICES];
    bit          voice_gate_tb  [NUM_VOICES];
    bit          voice_live_tb  [NUM_VOICES];
    logic [31:0] voice_stamp_tb [NUM_VOICES];
    logic [31:0] stamp_next_tb;
    logic [31:0] steals_tb;
    logic [3:0]  listen_ch;

    t_midi_event midi_backlog[$];       // events not yet on the bus
    t_result     alloc_results_due[$];  // results owed by the block, oldest first
    t_midi_event on_bus;                // payload currently driven

    int  src_gap;                       // remaining idle cycles on the input side
    int  sink_hold;                     // remaining stall cycles on the output side
    bit  calm;                          // no idling at all in the closing phase
    int  err_count;
    int  cycles;

    poly_voice_allocator_unit #(
        .VOICES(NUM_VOICES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_channel      (i_channel),
        .i_note         (i_note),
        .i_velocity     (i_velocity),
        .i_controller   (i_controller),
        .i_voice_index  (i_voice_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_action       (o_action),
        .o_voice_slot   (o_voice_slot),
        .o_stolen       (o_stolen),
        .o_release_mask (o_release_mask),
        .o_live_voices  (o_live_voices),
        .o_steal_total  (o_steal_total),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral allocator: applies one accepted event to the bench table and
    // returns the result beat the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic t_result apply_midi_event(t_midi_event ev);
        t_result r;
        int      v;
        int      n;
        bit      on_chan;
        bit      all;
        r       = '0;
        v       = -1;
        on_chan = (ev.chan == listen_ch);
        if (ev.cmd == CMD_NOTE_ON && on_chan && ev.vel != VEL_ZERO) begin
            // lowest idle voice, then lowest released one, then the oldest stamp
            for (int i = 0; i < NUM_VOICES; i++)
                if (v < 0 && !voice_live_tb[i])
                    v = i;
            for (int i = 0; i < NUM_VOICES; i++)
                if (v < 0 && !voice_gate_tb[i])
                    v = i;
            if (v < 0) begin
                v = 0;
                for (int i = 1; i < NUM_VOICES; i++)
                    if (voice_stamp_tb[i] < voice_stamp_tb[v])
                        v = i;
            end
            if (voice_live_tb[v] && voice_gate_tb[v]) begin
                r.stolen  = 1'b1;
                steals_tb = steals_tb + 32'd1;
            end
            voice_key_tb[v]   = ev.note;
            voice_vel_tb[v]   = ev.vel;
            voice_gate_tb[v]  = 1'b1;
            voice_live_tb[v]  = 1'b1;
            voice_stamp_tb[v] = stamp_next_tb;
            stamp_next_tb     = stamp_next_tb + 32'd1;
            r.action          = ACT_ASSIGN;
            r.voice_slot      = 3'(v);
        end else if ((ev.cmd == CMD_NOTE_ON || ev.cmd == CMD_NOTE_OFF) && on_chan
                     || ev.cmd == CMD_CTRL && on_chan
                        && (ev.ctl == CTL_ALL_SOUND_OFF || ev.ctl == CTL_ALL_NOTES_OFF)) begin
            // note release hits live voices on that key; the two controllers hit all
            all = (ev.cmd == CMD_CTRL);
            for (int i = 0; i < NUM_VOICES; i++) begin
                if (all || voice_live_tb[i] && voice_key_tb[i] == ev.note) begin
                    if (voice_gate_tb[i] && i < 8)
                        r.release_mask[i] = 1'b1;
                    voice_gate_tb[i] = 1'b0;
                end
            end
            r.action = all ? ACT_ALL_REL : ACT_NOTE_REL;
        end else if (ev.cmd == CMD_FINISHED && int'(ev.vidx) < NUM_VOICES) begin
            // envelope end only frees a voice whose gate is already off
            if (voice_live_tb[ev.vidx] && !voice_gate_tb[ev.vidx]) begin
                voice_live_tb[ev.vidx] = 1'b0;
                r.action               = ACT_FREED;
                r.voice_slot           = ev.vidx;
            end
        end
        n = 0;
        for (int i = 0; i < NUM_VOICES; i++)
            n += voice_live_tb[i] ? 1 : 0;
        r.live_voices = 4'(n);
        r.steal_total = steals_tb;
        return r;
    endfunction

    // Random event, mostly well-formed traffic on the listen channel with
    // notes from a narrow band so that releases and frees find their voices.
    function automatic t_midi_event random_midi_event();
        t_midi_event ev;
        int          pick;
        ev.cmd  = CMD_NOTE_ON;
        ev.chan = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : listen_ch;
        ev.note = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'(36 + 4 * $urandom_range(0, 7));
        ev.vel  = ($urandom_range(0, 19) == 0) ? VEL_ZERO : 7'($urandom_range(1, 127));
        ev.ctl  = 7'($urandom_range(0, 127));
        ev.vidx = 3'($urandom_range(0, 7));
        pick    = $urandom_range(0, 99);
        if (pick < 40) begin
            ev.cmd = CMD_NOTE_ON;
        end else if (pick < 60) begin
            ev.cmd = CMD_NOTE_OFF;
        end else if (pick < 70) begin
            ev.cmd = CMD_CTRL;
            if ($urandom_range(0, 1) == 1)
                ev.ctl = ($urandom_range(0, 1) == 1) ? CTL_ALL_SOUND_OFF : CTL_ALL_NOTES_OFF;
        end else if (pick < 90) begin
            ev.cmd = CMD_FINISHED;
        end else begin
            // raw noise across every field
            ev.cmd  = t_cmd'($urandom_range(0, 3));
            ev.chan = 4'($urandom_range(0, 15));
            ev.note = 7'($urandom_range(0, 127));
            ev.vel  = 7'($urandom_range(0, 127));
        end
        return ev;
    endfunction

    task automatic queue_event(input t_cmd cmd, input int chan, input int note,
                               input int vel, input int ctl, input int vidx);
        t_midi_event ev;
        ev.cmd  = cmd;
        ev.chan = 4'(chan);
        ev.note = 7'(note);
        ev.vel  = 7'(vel);
        ev.ctl  = 7'(ctl);
        ev.vidx = 3'(vidx);
        midi_backlog.push_back(ev);
    endtask

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Checked at the falling edge, where every update of the rising edge has
    // landed, so a beat just popped for the bus is never missed.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (midi_backlog.size() != 0 || i_valid || alloc_results_due.size() != 0);
    endtask

    // Block is quiet here; the wait before the write covers its return to idle.
    task automatic write_listen_channel(input logic [3:0] value);
        repeat (16) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        listen_ch   = value;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents one beat at a time from the backlog. A stalled beat is
    // held untouched; between beats random idle bursts are inserted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap  = 0;
        end else begin
            if (i_valid && !o_stall)
                alloc_results_due.push_back(apply_midi_event(on_bus));
            if (!(i_valid && o_stall)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (midi_backlog.size() != 0) begin
                    on_bus         = midi_backlog.pop_front();
                    i_command     <= on_bus.cmd;
                    i_channel     <= on_bus.chan;
                    i_note        <= on_bus.note;
                    i_velocity    <= on_bus.vel;
                    i_controller  <= on_bus.ctl;
                    i_voice_index <= on_bus.vidx;
                    i_valid       <= 1'b1;
                    // arm an idle burst to follow this beat
                    if (!calm && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 8);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each taken result beat against the oldest one due, and
    // throws random stall bursts at the output.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            sink_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (alloc_results_due.size() == 0) begin
                    report_mismatch("result beat with no event outstanding");
                end else begin
                    due = alloc_results_due.pop_front();
                    if (o_action !== due.action)
                        report_mismatch($sformatf("action %0d, want %0d",
                                                  o_action, due.action));
                    if (o_voice_slot !== due.voice_slot)
                        report_mismatch($sformatf("voice_slot %0d, want %0d",
                                                  o_voice_slot, due.voice_slot));
                    if (o_stolen !== due.stolen)
                        report_mismatch($sformatf("stolen %0b, want %0b",
                                                  o_stolen, due.stolen));
                    if (o_release_mask !== due.release_mask)
                        report_mismatch($sformatf("release_mask %h, want %h",
                                                  o_release_mask, due.release_mask));
                    if (o_live_voices !== due.live_voices)
                        report_mismatch($sformatf("live_voices %0d, want %0d",
                                                  o_live_voices, due.live_voices));
                    if (o_steal_total !== due.steal_total)
                        report_mismatch($sformatf("steal_total %0d, want %0d",
                                                  o_steal_total, due.steal_total));
                end
            end
            if (calm) begin
                i_stall <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                sink_hold = $urandom_range(1, 8) - 1;
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [3:0] chan;
        for (int i = 0; i < NUM_VOICES; i++) begin
            voice_key_tb[i]   = NOTE_RESET;
            voice_vel_tb[i]   = VEL_ZERO;
            voice_gate_tb[i]  = 1'b0;
            voice_live_tb[i]  = 1'b0;
            voice_stamp_tb[i] = '0;
        end
        stamp_next_tb = 32'd1;
        steals_tb     = '0;
        listen_ch     = '0;
        calm          = 1'b0;
        err_count     = 0;
        cycles        = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: listen channel still at its reset value of zero.
        queue_event(CMD_NOTE_ON,  0,   0, 127,   0, 0);  // voice 0, lowest key
        queue_event(CMD_NOTE_ON,  0, 127,   1,   0, 0);  // voice 1, top key
        queue_event(CMD_NOTE_ON,  5,  64, 100,   0, 0);  // other channel: ignored
        queue_event(CMD_NOTE_OFF, 0,   0,  64,   0, 0);  // releases voice 0
        queue_event(CMD_NOTE_OFF, 0,  99,  64,   0, 0);  // no match, empty mask
        queue_event(CMD_FINISHED, 0,   0,   0,   0, 0);  // frees voice 0
        queue_event(CMD_FINISHED, 0,   0,   0,   0, 1);  // gate still on: ignored
        queue_event(CMD_FINISHED, 0,   0,   0,   0, 7);  // idle voice: ignored
        queue_event(CMD_NOTE_ON,  0, 127,   0,   0, 0);  // zero velocity releases
        queue_event(CMD_CTRL,     0,   0,   0,  64, 0);  // other controller
        queue_event(CMD_CTRL,     0,   0,   0, 120, 0);  // all off, nothing gated
        for (int k = 0; k < NUM_VOICES + 2; k++)          // fill the table, then steal
            queue_event(CMD_NOTE_ON, 0, 10 + k, 1 + 12 * k, 0, 0);
        queue_event(CMD_CTRL,    15,   0,   0, 123, 0);  // other channel: ignored
        queue_event(CMD_CTRL,     0,   0,   0, 123, 0);  // every gate cleared
        queue_event(CMD_FINISHED, 0,   0,   0,   0, 3);  // freed
        queue_event(CMD_FINISHED,15, 127, 127, 127, 5);  // channel plays no part
        wait_drained();

        // Random phases under different listen channels; last one has no idling.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: chan = 4'd15;
                2: chan = 4'd0;
                default: chan = 4'($urandom_range(0, 15));
            endcase
            write_listen_channel(chan);
            calm = (phase == 4);
            @(negedge i_clk);
            repeat (110) midi_backlog.push_back(random_midi_event());
            wait_drained();
        end

        // quiet tail: any stray beat here is flagged by the monitor
        repeat (24) @(posedge i_clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/poly_va_pkg.sv
rtl/poly_va_mem.sv
rtl/poly_va_seq.sv
rtl/poly_voice_allocator_unit.sv
verif/poly_voice_allocator_unit_tb.sv
